// ===== src/h2r_pkg.sv =====
package h2r_pkg;

  // Hue circle split into six sectors
  localparam int unsigned HueSector   = 10923;
  localparam int unsigned NumSectors  = 6;
  localparam int unsigned Sector5Bump = 2;

  // Rounded division by 43: floor((x + 21) / 43) = ((x + 21) * FracMul) >> FracShift
  localparam int unsigned FracHalf  = 21;
  localparam int unsigned FracMul   = 24386;
  localparam int unsigned FracShift = 20;

  // Rounded division by 254: remainder above 126 rounds up, so bias by 127,
  // done as ((x + 127) >> 1) / 127
  localparam int unsigned SatHalf  = 127;
  localparam int unsigned SatMul   = 33027;
  localparam int unsigned SatShift = 22;

  // Rounded division by 255
  localparam int unsigned ValHalf  = 127;
  localparam int unsigned ValMul   = 32897;
  localparam int unsigned ValShift = 23;

  // Register stages from input to output register
  localparam int unsigned NumStages = 7;

  typedef enum logic [2:0] {
    SEC_RED_TO_YELLOW   = 3'd0,
    SEC_YELLOW_TO_GREEN = 3'd1,
    SEC_GREEN_TO_CYAN   = 3'd2,
    SEC_CYAN_TO_BLUE    = 3'd3,
    SEC_BLUE_TO_MAGENTA = 3'd4,
    SEC_MAGENTA_TO_RED  = 3'd5
  } sector_e;

  typedef struct packed {
    logic [15:0] hue;
    logic [7:0]  saturation;
    logic [7:0]  brightness;
  } hsv_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Sector stage result
  typedef struct packed {
    sector_e     sector;
    logic [13:0] rem;
    logic [15:0] low_prod;
    logic [7:0]  sat;
    logic [7:0]  val;
  } sec_t;

  // Scale stages result
  typedef struct packed {
    sector_e     sector;
    logic [7:0]  low;
    logic [15:0] ramp_prod;
    logic [7:0]  val;
  } scl_t;

endpackage

// ===== src/hsv_to_rgb_integer_top.sv =====
// HSV to RGB converter: 16-bit hue, 8-bit saturation and 8-bit value in, 8-bit red,
// green and blue out, integer math with round-to-nearest on every quotient. The
// block takes one item per clock while in_stall_o is low. It is a seven-stage
// pipeline (sector split, the four rounded divides done as reciprocal multiplies
// with a register after each multiplier, and the final channel routing into the
// output register). Every stage has its own valid bit and moves whenever the
// stage after it is empty or moving, so bubbles are squeezed out and the input
// keeps flowing while a result waits on out_stall_i; in_stall_o only rises once
// all seven stages hold items. Zero value gives black without a special path,
// since low, ramp and falling ramp are all zero then.
module hsv_to_rgb_integer_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  h2r_pkg::hsv_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output h2r_pkg::rgb_t out_data_o
);

  localparam int unsigned NumStages = h2r_pkg::NumStages;

  // Stage enables: a stage loads when it is empty or its successor loads
  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] en;

  always_comb begin
    en[NumStages-1] = !vld_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = vld_q[NumStages-1];

  h2r_pkg::sec_t sec;
  h2r_pkg::scl_t scl;

  // Stage 1: sector and remainder, V * (255 - S)
  h2r_sector u_sector (
    .clk_i  (clk_i),
    .en_i   (en[0]),
    .data_i (in_data_i),
    .sec_o  (sec)
  );

  // Stages 2..5: low, fraction f, t and the t * V product
  h2r_scale u_scale (
    .clk_i (clk_i),
    .en_i  (en[4:1]),
    .sec_i (sec),
    .scl_o (scl)
  );

  // Stages 6..7: ramp, falling ramp, channel select, output register
  h2r_mix u_mix (
    .clk_i  (clk_i),
    .en_i   (en[6:5]),
    .scl_i  (scl),
    .data_o (out_data_o)
  );

endmodule

// ===== src/h2r_sector.sv =====
module h2r_sector (
  input  logic          clk_i,
  input  logic          en_i,
  input  h2r_pkg::hsv_t data_i,
  output h2r_pkg::sec_t sec_o
);

  h2r_pkg::sec_t sec_d, sec_q;
  logic [2:0]    cnt;
  logic [15:0]   base;
  logic [15:0]   rem_full;

  always_comb begin
    cnt  = '0;
    base = '0;
    for (int k = 1; k < h2r_pkg::NumSectors; k++) begin
      if (data_i.hue >= 16'(k * h2r_pkg::HueSector)) begin
        cnt  = 3'(k);
        base = 16'(k * h2r_pkg::HueSector);
      end
    end
    rem_full = data_i.hue - base;

    sec_d.sector = h2r_pkg::sector_e'(cnt);
    sec_d.rem    = 14'(rem_full);
    if (h2r_pkg::sector_e'(cnt) == h2r_pkg::SEC_MAGENTA_TO_RED) begin
      sec_d.rem = 14'(rem_full) + 14'(h2r_pkg::Sector5Bump);
    end
    // V * (255 - S), rounded later
    sec_d.low_prod = {8'd0, data_i.brightness} * {8'd0, 8'd255 - data_i.saturation};
    sec_d.sat      = data_i.saturation;
    sec_d.val      = data_i.brightness;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sec_q <= sec_d;
    end
  end

  assign sec_o = sec_q;

endmodule

// ===== src/h2r_scale.sv =====
module h2r_scale (
  input  logic          clk_i,
  input  logic [3:0]    en_i,
  input  h2r_pkg::sec_t sec_i,
  output h2r_pkg::scl_t scl_o
);

  typedef struct packed {
    h2r_pkg::sector_e sector;
    logic [28:0]      frac_mul;
    logic [31:0]      low_mul;
    logic [7:0]       sat;
    logic [7:0]       val;
  } stb_t;

  typedef struct packed {
    h2r_pkg::sector_e sector;
    logic [7:0]       low;
    logic [15:0]      sat_prod;
    logic [7:0]       val;
  } stc_t;

  typedef struct packed {
    h2r_pkg::sector_e sector;
    logic [7:0]       low;
    logic [30:0]      sat_mul;
    logic [7:0]       val;
  } std_t;

  stb_t b_d, b_q;
  stc_t c_d, c_q;
  std_t d_d, d_q;
  h2r_pkg::scl_t e_d, e_q;

  logic [13:0] frac_num;
  logic [15:0] low_num;
  logic [7:0]  frac;
  logic [16:0] sat_num;
  logic [14:0] sat_half;
  logic [7:0]  tint;

  // B: reciprocal products for f and low
  always_comb begin
    frac_num    = sec_i.rem + 14'(h2r_pkg::FracHalf);
    low_num     = sec_i.low_prod + 16'(h2r_pkg::ValHalf);
    b_d.sector  = sec_i.sector;
    b_d.frac_mul = 29'(frac_num) * 29'(h2r_pkg::FracMul);
    b_d.low_mul  = 32'(low_num) * 32'(h2r_pkg::ValMul);
    b_d.sat     = sec_i.sat;
    b_d.val     = sec_i.val;
  end

  // C: f * S
  always_comb begin
    frac       = 8'(b_q.frac_mul >> h2r_pkg::FracShift);
    c_d.sector = b_q.sector;
    c_d.low    = 8'(b_q.low_mul >> h2r_pkg::ValShift);
    c_d.sat_prod = {8'd0, frac} * {8'd0, b_q.sat};
    c_d.val    = b_q.val;
  end

  // D: divide by 254 as halve then divide by 127
  always_comb begin
    sat_num     = 17'(c_q.sat_prod) + 17'(h2r_pkg::SatHalf);
    sat_half    = 15'(sat_num >> 1);
    d_d.sector  = c_q.sector;
    d_d.low     = c_q.low;
    d_d.sat_mul = 31'(sat_half) * 31'(h2r_pkg::SatMul);
    d_d.val     = c_q.val;
  end

  // E: t * V
  always_comb begin
    tint          = 8'(d_q.sat_mul >> h2r_pkg::SatShift);
    e_d.sector    = d_q.sector;
    e_d.low       = d_q.low;
    e_d.ramp_prod = {8'd0, tint} * {8'd0, d_q.val};
    e_d.val       = d_q.val;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) b_q <= b_d;
    if (en_i[1]) c_q <= c_d;
    if (en_i[2]) d_q <= d_d;
    if (en_i[3]) e_q <= e_d;
  end

  assign scl_o = e_q;

endmodule

// ===== src/h2r_mix.sv =====
module h2r_mix (
  input  logic          clk_i,
  input  logic [1:0]    en_i,
  input  h2r_pkg::scl_t scl_i,
  output h2r_pkg::rgb_t data_o
);

  typedef struct packed {
    h2r_pkg::sector_e sector;
    logic [7:0]       low;
    logic [31:0]      ramp_mul;
    logic [7:0]       val;
  } stf_t;

  stf_t          f_d, f_q;
  h2r_pkg::rgb_t rgb_d, rgb_q;
  logic [15:0]   ramp_num;
  logic [7:0]    ramp;
  logic [7:0]    fall;

  // F: reciprocal product for ramp
  always_comb begin
    ramp_num     = scl_i.ramp_prod + 16'(h2r_pkg::ValHalf);
    f_d.sector   = scl_i.sector;
    f_d.low      = scl_i.low;
    f_d.ramp_mul = 32'(ramp_num) * 32'(h2r_pkg::ValMul);
    f_d.val      = scl_i.val;
  end

  // G: falling ramp and channel routing
  always_comb begin
    ramp = 8'(f_q.ramp_mul >> h2r_pkg::ValShift);
    fall = (ramp > f_q.val) ? 8'd0 : f_q.val - ramp;
    unique case (f_q.sector)
      h2r_pkg::SEC_RED_TO_YELLOW:   rgb_d = '{red: f_q.val, green: ramp,      blue: f_q.low};
      h2r_pkg::SEC_YELLOW_TO_GREEN: rgb_d = '{red: fall,    green: f_q.val,   blue: f_q.low};
      h2r_pkg::SEC_GREEN_TO_CYAN:   rgb_d = '{red: f_q.low, green: f_q.val,   blue: ramp};
      h2r_pkg::SEC_CYAN_TO_BLUE:    rgb_d = '{red: f_q.low, green: fall,      blue: f_q.val};
      h2r_pkg::SEC_BLUE_TO_MAGENTA: rgb_d = '{red: ramp,    green: f_q.low,   blue: f_q.val};
      h2r_pkg::SEC_MAGENTA_TO_RED:  rgb_d = '{red: f_q.val, green: f_q.low,   blue: fall};
      default:                      rgb_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) f_q   <= f_d;
    if (en_i[1]) rgb_q <= rgb_d;
  end

  assign data_o = rgb_q;

endmodule

// ===== src/h2r_check.sv =====
module h2r_check (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input h2r_pkg::hsv_t in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input h2r_pkg::rgb_t out_data_o
);

  logic [3:0] occ_d, occ_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_comb begin
    occ_d = occ_q;
    if (in_acc && !out_acc) occ_d = occ_q + 4'd1;
    if (!in_acc && out_acc) occ_d = occ_q - 4'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Input only backs up when the output is blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // Never more items in flight than pipeline stages
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= 4'(h2r_pkg::NumStages))
    else $error("too many items in flight");

  // No result without an item in flight
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> occ_q != 4'd0)
    else $error("result with no item in flight");

endmodule

bind hsv_to_rgb_integer_top h2r_check u_h2r_check (.*);
